// ----- src/salu_pkg.sv -----
// ----------------------------------------------------------------------------
// salu_pkg: shared types and constants of the signed ALU
// Opcodes, internal unit operations and the core status bundle.
// ----------------------------------------------------------------------------
package salu_pkg;

	localparam int HALF_BITS  = 64;
	localparam int MODE_BITS  = 4;
	localparam int SHAMT_BITS = 7;

	typedef enum logic [MODE_BITS-1:0] {
		MODE_ADD = 4'd0,
		MODE_SUB = 4'd1,
		MODE_MUL = 4'd2,
		MODE_DIV = 4'd3,
		MODE_AND = 4'd4,
		MODE_OR  = 4'd5,
		MODE_XOR = 4'd6,
		MODE_NOT = 4'd7,
		MODE_SAR = 4'd8,
		MODE_SHL = 4'd9,
		MODE_ROL = 4'd10,
		MODE_ROR = 4'd11
	} mode_t;

	typedef enum logic [3:0] {
		UOP_ZERO,
		UOP_ADD,
		UOP_SUB,
		UOP_AND,
		UOP_OR,
		UOP_XOR,
		UOP_NOT,
		UOP_SAR1,
		UOP_SHL1,
		UOP_ROL1,
		UOP_ROR1
	} uop_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic div_zero;
	} core_status_t;

	// Single-pass operations and the one-bit step of each shift or rotate.
	function automatic uop_t mode_to_uop(input mode_t m);
		uop_t u;
		case (m)
			MODE_ADD: u = UOP_ADD;
			MODE_SUB: u = UOP_SUB;
			MODE_AND: u = UOP_AND;
			MODE_OR:  u = UOP_OR;
			MODE_XOR: u = UOP_XOR;
			MODE_NOT: u = UOP_NOT;
			MODE_SAR: u = UOP_SAR1;
			MODE_SHL: u = UOP_SHL1;
			MODE_ROL: u = UOP_ROL1;
			MODE_ROR: u = UOP_ROR1;
			default:  u = UOP_ZERO;
		endcase
		return u;
	endfunction

endpackage

// ----- src/signed_128bit_alu_mul_div.sv -----
// ----------------------------------------------------------------------------
// signed_128bit_alu_mul_div: iterative two's-complement ALU
// Add, subtract, Booth multiply, restoring divide, logic, shifts, rotates.
// ----------------------------------------------------------------------------
// Usage:
//   A request enters on in_valid while in_stall is low; it carries an opcode,
//   operands a and b as 64-bit halves and a shift amount. Operands are
//   sign-extended or cut to WORD_BITS. One result leaves on out_valid and is
//   taken when out_stall is low; signed less and equal flags ride with it.
//   in_stall is high from the accept until the finished result moves into the
//   output register, so one request is in flight at a time. A finished
//   result may wait in the output register while the next request is taken.
//   How each operation runs (one shared adder/shifter serves them all):
//     add, sub, logic, unused codes: a single pass through the shared unit
//     multiply: one Booth step per multiplier bit
//     divide: two negations, one restoring step per bit, sign fix;
//       divide by zero skips straight to the result
//     shifts and rotates: one bit position per cycle
//   The next request is taken in the cycle after the result leaves the core.
//   Reset clears the sequencer and out_valid; no request is lost on a stall,
//   the core simply holds its result until the output register frees up.
// ----------------------------------------------------------------------------
module signed_128bit_alu_mul_div #(
	parameter int WORD_BITS = 128
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [salu_pkg::MODE_BITS-1:0]      mode,
	input  logic [salu_pkg::HALF_BITS-1:0]      a_high,
	input  logic [salu_pkg::HALF_BITS-1:0]      a_low,
	input  logic [salu_pkg::HALF_BITS-1:0]      b_high,
	input  logic [salu_pkg::HALF_BITS-1:0]      b_low,
	input  logic [salu_pkg::SHAMT_BITS-1:0]     shift_amount,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [salu_pkg::HALF_BITS-1:0]      result_high,
	output logic [salu_pkg::HALF_BITS-1:0]      result_low,
	output logic                                a_less_than_b,
	output logic                                a_equals_b,
	output logic                                divide_by_zero
);

	localparam int IN_BITS = 2 * salu_pkg::HALF_BITS;

	logic [WORD_BITS-1:0]           a_w;
	logic [WORD_BITS-1:0]           b_w;
	logic                           accept;
	logic                           take;
	logic [WORD_BITS-1:0]           core_res;
	logic [IN_BITS-1:0]             res_ext;
	salu_pkg::core_status_t         status;

	logic                           lt_q;
	logic                           eq_q;
	logic                           out_valid_q;
	logic [salu_pkg::HALF_BITS-1:0] res_hi_q;
	logic [salu_pkg::HALF_BITS-1:0] res_lo_q;
	logic                           lt_out_q;
	logic                           eq_out_q;
	logic                           dz_out_q;

	// fit the 128-bit operands to the working width
	assign a_w = WORD_BITS'($signed({a_high, a_low}));
	assign b_w = WORD_BITS'($signed({b_high, b_low}));

	// accept only while the core sits idle
	assign in_stall = status.busy;
	assign accept   = in_valid && !status.busy;

	// move the finished result out when the output register is free or draining
	assign take = status.done && (!out_valid_q || !out_stall);

	salu_core #(
		.WORD_BITS (WORD_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.mode   (salu_pkg::mode_t'(mode)),
		.shamt  (shift_amount),
		.a_w    (a_w),
		.b_w    (b_w),
		.take   (take),
		.result (core_res),
		.status (status)
	);

	// flags depend on the operands only: latch them at accept
	always_ff @(posedge clk) begin
		if (accept) begin
			lt_q <= ($signed(a_w) < $signed(b_w));
			eq_q <= (a_w == b_w);
		end
	end

	// sign-extend or cut the result back to 128 bits
	assign res_ext = IN_BITS'($signed(core_res));

	// output register: load on take, drop valid once the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				out_valid_q <= 1'b1;
				res_hi_q    <= res_ext[IN_BITS-1:salu_pkg::HALF_BITS];
				res_lo_q    <= res_ext[salu_pkg::HALF_BITS-1:0];
				lt_out_q    <= lt_q;
				eq_out_q    <= eq_q;
				dz_out_q    <= status.div_zero;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign result_high    = res_hi_q;
	assign result_low     = res_lo_q;
	assign a_less_than_b  = lt_out_q;
	assign a_equals_b     = eq_out_q;
	assign divide_by_zero = dz_out_q;

	// an accepted request sets the core busy, so no new one starts while a result is still inside it
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> status.busy)
		else $error("core not busy after accept");

	// an occupied, stalled output register is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !take)
		else $error("output register overwritten under stall");

	// divide by zero flag only comes out with a zero result
	a_dz_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && dz_out_q) |-> (res_hi_q == '0 && res_lo_q == '0))
		else $error("divide by zero with nonzero result");

endmodule

// ----- src/salu_unit.sv -----
// ----------------------------------------------------------------------------
// salu_unit: shared arithmetic and shift unit
// One adder/subtractor with carry out, bitwise logic and one-bit shifts and rotates.
// ----------------------------------------------------------------------------
module salu_unit #(
	parameter int WORD_BITS = 128
) (
	input  salu_pkg::uop_t        op,
	input  logic [WORD_BITS-1:0]  x,
	input  logic [WORD_BITS-1:0]  y,
	output logic [WORD_BITS-1:0]  sum,
	output logic                  cout
);

	logic                 inv;
	logic [WORD_BITS:0]   add_full;

	assign inv      = (op == salu_pkg::UOP_SUB);
	assign add_full = {1'b0, x} + {1'b0, y ^ {WORD_BITS{inv}}} + (WORD_BITS + 1)'(inv);
	assign cout     = add_full[WORD_BITS];

	always_comb begin
		case (op)
			salu_pkg::UOP_ADD,
			salu_pkg::UOP_SUB:  sum = add_full[WORD_BITS-1:0];
			salu_pkg::UOP_AND:  sum = x & y;
			salu_pkg::UOP_OR:   sum = x | y;
			salu_pkg::UOP_XOR:  sum = x ^ y;
			salu_pkg::UOP_NOT:  sum = ~x;
			salu_pkg::UOP_SAR1: sum = {x[WORD_BITS-1], x[WORD_BITS-1:1]};
			salu_pkg::UOP_SHL1: sum = {x[WORD_BITS-2:0], 1'b0};
			salu_pkg::UOP_ROL1: sum = {x[WORD_BITS-2:0], x[WORD_BITS-1]};
			salu_pkg::UOP_ROR1: sum = {x[0], x[WORD_BITS-1:1]};
			default:            sum = '0;
		endcase
	end

endmodule

// ----- src/salu_core.sv -----
// ----------------------------------------------------------------------------
// salu_core: sequencer around the shared unit
// Booth radix-2 multiply, restoring divide, bit-serial shifts and
// single-pass operations, one request at a time.
// ----------------------------------------------------------------------------
module salu_core #(
	parameter int WORD_BITS = 128
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  salu_pkg::mode_t                 mode,
	input  logic [salu_pkg::SHAMT_BITS-1:0] shamt,
	input  logic [WORD_BITS-1:0]            a_w,
	input  logic [WORD_BITS-1:0]            b_w,
	input  logic                            take,
	output logic [WORD_BITS-1:0]            result,
	output salu_pkg::core_status_t          status
);

	localparam int CNT_RAW = $clog2(WORD_BITS + 1);
	localparam int CNT_W   = (CNT_RAW > salu_pkg::SHAMT_BITS) ? CNT_RAW : salu_pkg::SHAMT_BITS;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXEC,
		ST_NEG_A,
		ST_NEG_B,
		ST_DIV,
		ST_FIXQ,
		ST_MUL,
		ST_SHIFT,
		ST_DONE
	} state_t;

	state_t                 state_q;
	salu_pkg::mode_t        mode_q;
	logic [WORD_BITS-1:0]   acc_q;
	logic [WORD_BITS-1:0]   x_q;
	logic [WORD_BITS-1:0]   y_q;
	logic                   booth_q;
	logic                   sign_a_q;
	logic                   sign_b_q;
	logic                   dz_q;
	logic [CNT_W-1:0]       cnt_q;

	salu_pkg::uop_t         u_op;
	logic [WORD_BITS-1:0]   u_x;
	logic [WORD_BITS-1:0]   u_y;
	logic [WORD_BITS-1:0]   u_sum;
	logic                   u_cout;
	logic [WORD_BITS-1:0]   rem_sh;

	// shift next dividend bit into the partial remainder
	assign rem_sh = {acc_q[WORD_BITS-2:0], x_q[WORD_BITS-1]};

	always_comb begin
		u_op = salu_pkg::UOP_ZERO;
		u_x  = x_q;
		u_y  = y_q;
		case (state_q)
			ST_EXEC: begin
				u_op = salu_pkg::mode_to_uop(mode_q);
			end
			ST_NEG_A, ST_FIXQ: begin
				u_op = salu_pkg::UOP_SUB;
				u_x  = '0;
				u_y  = x_q;
			end
			ST_NEG_B: begin
				u_op = salu_pkg::UOP_SUB;
				u_x  = '0;
			end
			ST_DIV: begin
				u_op = salu_pkg::UOP_SUB;
				u_x  = rem_sh;
			end
			ST_MUL: begin
				u_op = y_q[0] ? salu_pkg::UOP_SUB : salu_pkg::UOP_ADD;
				u_x  = acc_q;
				u_y  = x_q;
			end
			ST_SHIFT: begin
				u_op = salu_pkg::mode_to_uop(mode_q);
				u_x  = acc_q;
			end
			default: begin
				u_op = salu_pkg::UOP_ZERO;
			end
		endcase
	end

	salu_unit #(
		.WORD_BITS (WORD_BITS)
	) u_unit (
		.op   (u_op),
		.x    (u_x),
		.y    (u_y),
		.sum  (u_sum),
		.cout (u_cout)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						mode_q   <= mode;
						x_q      <= a_w;
						y_q      <= b_w;
						acc_q    <= '0;
						booth_q  <= 1'b0;
						dz_q     <= 1'b0;
						sign_a_q <= a_w[WORD_BITS-1];
						sign_b_q <= b_w[WORD_BITS-1];
						cnt_q    <= CNT_W'(WORD_BITS);
						case (mode)
							salu_pkg::MODE_MUL: begin
								state_q <= ST_MUL;
							end
							salu_pkg::MODE_DIV: begin
								if (b_w == '0) begin
									dz_q    <= 1'b1;
									state_q <= ST_DONE;
								end else begin
									state_q <= ST_NEG_A;
								end
							end
							salu_pkg::MODE_SAR, salu_pkg::MODE_SHL,
							salu_pkg::MODE_ROL, salu_pkg::MODE_ROR: begin
								acc_q   <= a_w;
								cnt_q   <= CNT_W'(shamt);
								state_q <= (shamt == '0) ? ST_DONE : ST_SHIFT;
							end
							default: begin
								state_q <= ST_EXEC;
							end
						endcase
					end
				end
				ST_EXEC: begin
					acc_q   <= u_sum;
					state_q <= ST_DONE;
				end
				ST_NEG_A: begin
					if (sign_a_q) begin
						x_q <= u_sum;
					end
					state_q <= ST_NEG_B;
				end
				ST_NEG_B: begin
					if (sign_b_q) begin
						y_q <= u_sum;
					end
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					acc_q <= u_cout ? u_sum : rem_sh;
					x_q   <= {x_q[WORD_BITS-2:0], u_cout};
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == CNT_W'(1)) begin
						state_q <= ST_FIXQ;
					end
				end
				ST_FIXQ: begin
					acc_q   <= (sign_a_q ^ sign_b_q) ? u_sum : x_q;
					state_q <= ST_DONE;
				end
				ST_MUL: begin
					if (y_q[0] != booth_q) begin
						acc_q <= u_sum;
					end
					x_q     <= {x_q[WORD_BITS-2:0], 1'b0};
					y_q     <= {1'b0, y_q[WORD_BITS-1:1]};
					booth_q <= y_q[0];
					cnt_q   <= cnt_q - CNT_W'(1);
					if (cnt_q == CNT_W'(1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_SHIFT: begin
					acc_q <= u_sum;
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == CNT_W'(1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result          = acc_q;
	assign status.busy     = (state_q != ST_IDLE);
	assign status.done     = (state_q == ST_DONE);
	assign status.div_zero = dz_q;

	// partial remainder always stays below the divisor magnitude
	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (acc_q < y_q))
		else $error("divide remainder not below divisor");

	// iterative states never run with an exhausted counter
	a_cnt_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL || state_q == ST_DIV || state_q == ST_SHIFT) |-> (cnt_q != '0))
		else $error("iteration counter ran out");

	// a finished result is held until the output side takes it
	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && !take) |=> (state_q == ST_DONE && $stable(acc_q)))
		else $error("result dropped before it was taken");

	// divide by zero returns a zero quotient
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && dz_q) |-> (acc_q == '0))
		else $error("divide by zero result not zero");

endmodule
